FILE: rtl/tbgd_pkg.sv
// Shared types and constants of the two-button gesture detector.
`timescale 1ns / 1ps
`default_nettype none

package tbgd_pkg;

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_EDGE  = 2'd0,
      KIND_POLL  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   // Configuration register indexes.
   localparam logic CSR_LONG_PRESS = 1'b0;
   localparam logic CSR_DUAL_LONG  = 1'b1;

   localparam int unsigned THR_W  = 24;
   localparam int unsigned TIME_W = 32;

   localparam logic [THR_W-1:0] LONG_PRESS_RESET = 24'd500000;
   localparam logic [THR_W-1:0] DUAL_LONG_RESET  = 24'd800000;

   // Sticky gesture events.
   typedef struct packed {
      logic dual_long;
      logic dual_press;
      logic right_long;
      logic right_short;
      logic left_long;
      logic left_short;
   } events_type;

   // What one button's poll evaluation decides.
   typedef struct packed {
      logic long_done;
      logic set_short;
      logic set_long;
   } btn_res_type;

endpackage

`default_nettype wire

FILE: rtl/two_button_gesture_detector.sv
// Top level of the two-button gesture detector.
// Two-button gesture detector. Every request (pin edge, poll or clear) produces exactly one
// response that reports the six sticky events and both button levels as they stand after
// the request. A request is taken into an input register and is then evaluated by
// a single pass of compare-and-flag logic whose results land directly in the state
// registers, which also serve as the response register. rsp_valid rises at the edge that
// loads the state registers. The block sustains one request per clock as long as the
// response side does not stall. A stalled response holds the next request in the input
// register, and once that register is full req_stall stays high until the response is
// taken. Time is a wrapping 32-bit microsecond stamp and every hold time is computed
// modulo 2^32. The two hold thresholds are written through the csr port
// (index 0 single long press, index 1 dual long) and must only be changed while idle.
`timescale 1ns / 1ps
`default_nettype none

module two_button_gesture_detector (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_kind,
   input  wire logic        req_button,
   input  wire logic        req_level,
   input  wire logic [31:0] req_now_us,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_left_short,
   output logic             rsp_left_long,
   output logic             rsp_right_short,
   output logic             rsp_right_long,
   output logic             rsp_dual_press,
   output logic             rsp_dual_long,
   output logic             rsp_left_held,
   output logic             rsp_right_held,

   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [23:0] csr_wdata
);

   // Configuration registers.
   logic [tbgd_pkg::THR_W-1:0] long_press_ff;
   logic [tbgd_pkg::THR_W-1:0] dual_long_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff <= tbgd_pkg::LONG_PRESS_RESET;
         dual_long_ff  <= tbgd_pkg::DUAL_LONG_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            tbgd_pkg::CSR_LONG_PRESS: long_press_ff <= csr_wdata;
            tbgd_pkg::CSR_DUAL_LONG:  dual_long_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register. It advances into the state/response stage whenever that stage is
   // empty or its response is being taken in this cycle.
   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   logic [1:0]                  s1_kind_ff;
   logic                        s1_button_ff;
   logic                        s1_level_ff;
   logic [tbgd_pkg::TIME_W-1:0] s1_now_ff;
   logic                        s1_adv;
   logic                        req_take;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_adv);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff   <= req_kind;
         s1_button_ff <= req_button;
         s1_level_ff  <= req_level;
         s1_now_ff    <= req_now_us;
      end
   end

   // Gesture state. It changes only when a request advances, which is also exactly when a
   // new response is loaded, so these registers double as the response payload.
   logic                        left_level_ff,   left_level_in;
   logic                        right_level_ff,  right_level_in;
   logic                        left_rel_ff,     left_rel_in;
   logic                        right_rel_ff,    right_rel_in;
   logic [tbgd_pkg::TIME_W-1:0] left_start_ff,   left_start_in;
   logic [tbgd_pkg::TIME_W-1:0] right_start_ff,  right_start_in;
   logic                        left_ld_ff,      left_ld_in;
   logic                        right_ld_ff,     right_ld_in;
   logic                        both_active_ff,  both_active_in;
   logic [tbgd_pkg::TIME_W-1:0] both_start_ff,   both_start_in;
   logic                        both_ld_ff,      both_ld_in;
   tbgd_pkg::events_type        events_ff,       events_in;

   tbgd_pkg::btn_res_type       left_res;
   tbgd_pkg::btn_res_type       right_res;
   logic [tbgd_pkg::TIME_W-1:0] dual_held_us;
   logic                        dual_reached;
   logic                        both_down;
   tbgd_pkg::kind_type          s1_kind;

   assign s1_kind = tbgd_pkg::kind_type'(s1_kind_ff);

   tbgd_button u_left (
      .now_us       (s1_now_ff),
      .start_us     (left_start_ff),
      .threshold_us (long_press_ff),
      .down         (left_level_ff),
      .released     (left_rel_ff),
      .long_done    (left_ld_ff),
      .res          (left_res)
   );

   tbgd_button u_right (
      .now_us       (s1_now_ff),
      .start_us     (right_start_ff),
      .threshold_us (long_press_ff),
      .down         (right_level_ff),
      .released     (right_rel_ff),
      .long_done    (right_ld_ff),
      .res          (right_res)
   );

   assign both_down    = left_level_ff && right_level_ff;
   assign dual_held_us = s1_now_ff - both_start_ff;
   assign dual_reached = dual_held_us >=
                         {{(tbgd_pkg::TIME_W-tbgd_pkg::THR_W){1'b0}}, dual_long_ff};

   always_comb begin
      left_level_in  = left_level_ff;
      right_level_in = right_level_ff;
      left_rel_in    = left_rel_ff;
      right_rel_in   = right_rel_ff;
      left_start_in  = left_start_ff;
      right_start_in = right_start_ff;
      left_ld_in     = left_ld_ff;
      right_ld_in    = right_ld_ff;
      both_active_in = both_active_ff;
      both_start_in  = both_start_ff;
      both_ld_in     = both_ld_ff;
      events_in      = events_ff;

      if (s1_adv) begin
         unique case (s1_kind)
            tbgd_pkg::KIND_EDGE: begin
               // A press stamps the start time; a release leaves a pending release
               // for the next poll to judge.
               if (!s1_button_ff) begin
                  left_level_in = s1_level_ff;
                  if (s1_level_ff) begin
                     left_start_in = s1_now_ff;
                  end else begin
                     left_rel_in = 1'b1;
                  end
               end else begin
                  right_level_in = s1_level_ff;
                  if (s1_level_ff) begin
                     right_start_in = s1_now_ff;
                  end else begin
                     right_rel_in = 1'b1;
                  end
               end
            end
            tbgd_pkg::KIND_POLL: begin
               // Every poll consumes the pending releases, even during a dual gesture.
               left_rel_in  = 1'b0;
               right_rel_in = 1'b0;
               if (both_down) begin
                  if (!both_active_ff) begin
                     // Start of a dual gesture: single long flags are forced so that
                     // neither button reports a single event afterwards.
                     both_active_in       = 1'b1;
                     events_in.dual_press = 1'b1;
                     both_start_in        = s1_now_ff;
                     both_ld_in           = 1'b0;
                     left_ld_in           = 1'b1;
                     right_ld_in          = 1'b1;
                  end else if (!both_ld_ff && dual_reached) begin
                     both_ld_in          = 1'b1;
                     events_in.dual_long = 1'b1;
                  end
               end
               if (both_down || both_active_ff) begin
                  // A dual gesture is active; it ends only once both buttons are up.
                  if (!left_level_ff && !right_level_ff) begin
                     both_active_in = 1'b0;
                     left_ld_in     = 1'b0;
                     right_ld_in    = 1'b0;
                     both_ld_in     = 1'b0;
                  end
               end else begin
                  left_ld_in  = left_res.long_done;
                  right_ld_in = right_res.long_done;
                  events_in.left_long   = events_ff.left_long   || left_res.set_long;
                  events_in.left_short  = events_ff.left_short  || left_res.set_short;
                  events_in.right_long  = events_ff.right_long  || right_res.set_long;
                  events_in.right_short = events_ff.right_short || right_res.set_short;
               end
            end
            tbgd_pkg::KIND_CLEAR: begin
               events_in = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_level_ff  <= 1'b0;
         right_level_ff <= 1'b0;
         left_rel_ff    <= 1'b0;
         right_rel_ff   <= 1'b0;
         left_start_ff  <= '0;
         right_start_ff <= '0;
         left_ld_ff     <= 1'b0;
         right_ld_ff    <= 1'b0;
         both_active_ff <= 1'b0;
         both_start_ff  <= '0;
         both_ld_ff     <= 1'b0;
         events_ff      <= '0;
      end else begin
         left_level_ff  <= left_level_in;
         right_level_ff <= right_level_in;
         left_rel_ff    <= left_rel_in;
         right_rel_ff   <= right_rel_in;
         left_start_ff  <= left_start_in;
         right_start_ff <= right_start_in;
         left_ld_ff     <= left_ld_in;
         right_ld_ff    <= right_ld_in;
         both_active_ff <= both_active_in;
         both_start_ff  <= both_start_in;
         both_ld_ff     <= both_ld_in;
         events_ff      <= events_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_short  = events_ff.left_short;
   assign rsp_left_long   = events_ff.left_long;
   assign rsp_right_short = events_ff.right_short;
   assign rsp_right_long  = events_ff.right_long;
   assign rsp_dual_press  = events_ff.dual_press;
   assign rsp_dual_long   = events_ff.dual_long;
   assign rsp_left_held   = left_level_ff;
   assign rsp_right_held  = right_level_ff;

`ifndef ASSERT_OFF
   // The dual long hold can only be marked while a dual gesture is active.
   assert property (@(posedge clock) disable iff (reset)
      both_ld_ff |-> both_active_ff)
      else $error("dual long flag set outside a dual gesture");

   // The input side only stalls while the input register holds a request.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with an empty input register");

   // Every request that advances shows up as a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid)
      else $error("advanced request produced no response");

   // A clear request leaves no sticky event behind.
   assert property (@(posedge clock) disable iff (reset)
      (s1_adv && (s1_kind == tbgd_pkg::KIND_CLEAR)) |=> (events_ff == '0))
      else $error("sticky events survived a clear request");
`endif

endmodule

`default_nettype wire

FILE: rtl/tbgd_button.sv
// Single-button long and short press evaluation for one poll request.
`timescale 1ns / 1ps
`default_nettype none

module tbgd_button (
   input  wire logic [tbgd_pkg::TIME_W-1:0] now_us,
   input  wire logic [tbgd_pkg::TIME_W-1:0] start_us,
   input  wire logic [tbgd_pkg::THR_W-1:0]  threshold_us,
   input  wire logic                        down,
   input  wire logic                        released,
   input  wire logic                        long_done,
   output tbgd_pkg::btn_res_type            res
);

   logic [tbgd_pkg::TIME_W-1:0] held_us;
   logic                        reached;
   logic                        fire_long;
   logic                        done_now;

   // Hold time is taken modulo 2^32 so a wrapping timestamp still works.
   assign held_us   = now_us - start_us;
   assign reached   = held_us >= {{(tbgd_pkg::TIME_W-tbgd_pkg::THR_W){1'b0}}, threshold_us};
   assign fire_long = down && !long_done && reached;
   assign done_now  = long_done || fire_long;

   assign res.set_long  = fire_long;
   assign res.set_short = released && !done_now;
   assign res.long_done = done_now && !released;

endmodule

`default_nettype wire
